// ----- hw/rtl/rpn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative path normalizer package
// Character codes, result item type and sizing constants for the normalizer.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int MAX_LENGTH_DEF = 256;

  // Results one request can produce: separator, two held dots, a byte, status.
  localparam int MAX_RES = 5;
  localparam int QDEPTH  = 8;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] CH_NONE   = 8'h00;

  localparam logic [1:0] DOTS_TWO = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic [7:0] chr;
    logic       is_st;
    logic       st;
    logic       last;
  } rpn_item_t;

endpackage

// ----- hw/rtl/relative_path_normalizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative path normalizer
// Normalizes a relative path arriving one byte per request and emits the
// normalized bytes followed by one status item per path.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    path_byte, has_byte, path_end
//  out_     output     out_valid / out_ready  char, is_status, status, last_of_run
//
// Each accepted request is decoded combinationally against the path state and
// its zero to five results are written into an eight-entry output queue.
// One request is taken per cycle while the queue has room for five results.
// The queue drains one result per cycle when out_ready is high.
// Synchronous active-low reset clears the path state and empties the queue.
module relative_path_normalizer
  import rpn_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_path_byte,
  input  logic       in_has_byte,
  input  logic       in_path_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_is_status,
  output logic       out_status,
  output logic       out_last_of_run
);

  localparam int CW   = $clog2(MAX_LENGTH + 2);
  localparam int QAW  = $clog2(QDEPTH);
  localparam int QCW  = QAW + 1;
  localparam int RIW  = $clog2(MAX_RES);
  localparam int RCW  = $clog2(MAX_RES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LENGTH);

  logic [CW-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [1:0]     held_r, held_nxt;
  logic           seg_r, seg_nxt;
  logic           ne_r, ne_nxt;
  logic           err_r, err_nxt;

  rpn_item_t      res [MAX_RES];
  logic [RCW-1:0] nres;

  rpn_item_t      mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] fill_r, fill_nxt;

  logic           acc, pop, bad;
  logic [7:0]     b_lc;
  logic           is_sep, is_ctl;
  logic [QAW-1:0] slot [QDEPTH];

  assign acc      = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = fill_r <= QCW'(QDEPTH - MAX_RES);

  assign is_sep = (in_path_byte == CH_SLASH) || (in_path_byte == CH_BSLASH);
  assign is_ctl = (in_path_byte < CH_SPACE) || (in_path_byte == CH_DEL) ||
                  (in_path_byte == CH_COLON);
  assign b_lc   = ((in_path_byte >= CH_UPPER_A) && (in_path_byte <= CH_UPPER_Z)) ?
                  (in_path_byte | CASE_BIT) : in_path_byte;
  assign cnt_inc = (cnt_r <= MAX_CNT) ? cnt_r + CW'(1) : cnt_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    held_nxt = held_r;
    seg_nxt  = seg_r;
    ne_nxt   = ne_r;
    err_nxt  = err_r;
    nres     = '0;
    bad      = 1'b0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end

    if (acc && in_has_byte && !err_r) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc > MAX_CNT) begin
        err_nxt = 1'b1;
      end else if (is_ctl) begin
        err_nxt = 1'b1;
      end else if (is_sep) begin
        if (cnt_r == '0) begin
          err_nxt = 1'b1;
        end else if (seg_r) begin
          seg_nxt  = 1'b0;
          held_nxt = '0;
        end else if (held_r == DOTS_TWO) begin
          err_nxt = 1'b1;
        end else begin
          held_nxt = '0;
        end
      end else if (seg_r) begin
        res[RIW'(nres)] = '{chr: b_lc, is_st: 1'b0, st: STATUS_OK, last: 1'b0};
        nres = nres + RCW'(1);
      end else if ((b_lc == CH_DOT) && (held_r < DOTS_TWO)) begin
        held_nxt = held_r + 2'd1;
      end else begin
        if (ne_r) begin
          res[RIW'(nres)] = '{chr: CH_SLASH, is_st: 1'b0, st: STATUS_OK, last: 1'b0};
          nres = nres + RCW'(1);
        end
        if (held_r != '0) begin
          res[RIW'(nres)] = '{chr: CH_DOT, is_st: 1'b0, st: STATUS_OK, last: 1'b0};
          nres = nres + RCW'(1);
        end
        if (held_r == DOTS_TWO) begin
          res[RIW'(nres)] = '{chr: CH_DOT, is_st: 1'b0, st: STATUS_OK, last: 1'b0};
          nres = nres + RCW'(1);
        end
        res[RIW'(nres)] = '{chr: b_lc, is_st: 1'b0, st: STATUS_OK, last: 1'b0};
        nres     = nres + RCW'(1);
        held_nxt = '0;
        seg_nxt  = 1'b1;
        ne_nxt   = 1'b1;
      end
    end

    if (acc && in_path_end) begin
      bad = err_nxt || (cnt_nxt == '0) || (!seg_nxt && (held_nxt == DOTS_TWO)) ||
            !ne_nxt;
      res[RIW'(nres)] = '{chr: CH_NONE, is_st: 1'b1,
                          st: bad ? STATUS_BAD : STATUS_OK, last: 1'b0};
      nres     = nres + RCW'(1);
      cnt_nxt  = '0;
      held_nxt = '0;
      seg_nxt  = 1'b0;
      ne_nxt   = 1'b0;
      err_nxt  = 1'b0;
    end

    if (nres != '0) begin
      res[RIW'(nres - RCW'(1))].last = 1'b1;
    end
  end

  assign fill_nxt = fill_r + QCW'(nres) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      held_r   <= '0;
      seg_r    <= 1'b0;
      ne_r     <= 1'b0;
      err_r    <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      held_r   <= held_nxt;
      seg_r    <= seg_nxt;
      ne_r     <= ne_nxt;
      err_r    <= err_nxt;
      wr_ptr_r <= wr_ptr_r + QAW'(nres);
      rd_ptr_r <= rd_ptr_r + QAW'(pop);
      fill_r   <= fill_nxt;
    end
  end

  always_comb begin
    for (int j = 0; j < QDEPTH; j++) begin
      slot[j] = QAW'(j) - wr_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QDEPTH; j++) begin
      if (QCW'(slot[j]) < QCW'(nres)) begin
        mem_r[j] <= res[RIW'(slot[j])];
      end
    end
  end

  assign out_valid       = fill_r != '0;
  assign out_char        = mem_r[rd_ptr_r].chr;
  assign out_is_status   = mem_r[rd_ptr_r].is_st;
  assign out_status      = mem_r[rd_ptr_r].st;
  assign out_last_of_run = mem_r[rd_ptr_r].last;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QCW'(QDEPTH))
    else $error("output queue fill exceeds its depth");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= DOTS_TWO)
    else $error("more than two dots held back");

  a_path_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_path_end) |=> (cnt_r == '0) && !err_r && !seg_r && !ne_r &&
                             (held_r == '0))
    else $error("path state not cleared after path end");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !acc) |=> fill_r == $past(fill_r) - QCW'(1))
    else $error("queue fill did not drop by one on a lone read");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative path normalizer testbench
// Drives whole paths into the normalizer under random stalls on both sides,
// predicts the normalized byte stream and the status of each path, and
// checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import rpn_pkg::*;

  localparam int RANDOM_ITEMS   = 355;
  localparam int QUIET_FROM     = 320;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;

  typedef logic [7:0] byte_q_t[$];

  class normalizer_scoreboard;
    int unsigned bytes_seen;
    logic [1:0]  held_dots;
    bit          segment_open;
    bit          output_nonempty;
    bit          error_seen;
    int          errors;
    rpn_item_t   normalized_q[$];

    function void clear_path();
      bytes_seen = 0;
      held_dots = 2'd0;
      segment_open = 1'b0;
      output_nonempty = 1'b0;
      error_seen = 1'b0;
    endfunction

    function void push(logic [7:0] chr, logic is_st, logic st);
      rpn_item_t item;
      item.chr = chr;
      item.is_st = is_st;
      item.st = st;
      item.last = 1'b0;
      normalized_q = {normalized_q, item};
    endfunction

    function void apply_request(logic [7:0] path_byte, logic has_byte, logic path_end);
      logic [7:0] b;
      bit         first;
      bit         sep;
      bit         bad;
      int         before_cnt;
      before_cnt = normalized_q.size();
      if (has_byte && !error_seen) begin
        b = path_byte;
        first = (bytes_seen == 0);
        sep = (b == CH_SLASH) || (b == CH_BSLASH);
        if (bytes_seen <= MAX_LENGTH_DEF) bytes_seen++;
        if (bytes_seen > MAX_LENGTH_DEF) begin
          error_seen = 1'b1;
        end else if (b < CH_SPACE || b == CH_DEL || b == CH_COLON) begin
          error_seen = 1'b1;
        end else if (sep) begin
          if (first || (!segment_open && held_dots == DOTS_TWO)) begin
            error_seen = 1'b1;
          end else begin
            segment_open = 1'b0;
            held_dots = 2'd0;
          end
        end else begin
          if (b >= CH_UPPER_A && b <= CH_UPPER_Z) b = b | CASE_BIT;
          if (segment_open) begin
            push(b, 1'b0, STATUS_OK);
          end else if (b == CH_DOT && held_dots < DOTS_TWO) begin
            held_dots++;
          end else begin
            if (output_nonempty) push(CH_SLASH, 1'b0, STATUS_OK);
            repeat (held_dots) push(CH_DOT, 1'b0, STATUS_OK);
            push(b, 1'b0, STATUS_OK);
            held_dots = 2'd0;
            segment_open = 1'b1;
            output_nonempty = 1'b1;
          end
        end
      end
      if (path_end) begin
        bad = error_seen || bytes_seen == 0 || (!segment_open && held_dots == DOTS_TWO) ||
              !output_nonempty;
        push(CH_NONE, 1'b1, bad ? STATUS_BAD : STATUS_OK);
        clear_path();
      end
      if (normalized_q.size() > before_cnt) normalized_q[normalized_q.size() - 1].last = 1'b1;
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(rpn_item_t got);
      rpn_item_t want;
      if (normalized_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual char %h status %b/%b last %b",
                 $time, got.chr, got.is_st, got.st, got.last);
        return;
      end
      want = normalized_q.pop_front();
      if (got.chr !== want.chr) report("out_char", want.chr, got.chr);
      if (got.is_st !== want.is_st) report("out_is_status", want.is_st, got.is_st);
      if (got.st !== want.st) report("out_status", want.st, got.st);
      if (got.last !== want.last) report("out_last_of_run", want.last, got.last);
    endfunction

    function int pending();
      return normalized_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_path_byte = 8'h00;
  logic       in_has_byte = 1'b0;
  logic       in_path_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_is_status;
  logic       out_status;
  logic       out_last_of_run;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  normalizer_scoreboard board = new;

  relative_path_normalizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_path_byte   (in_path_byte),
    .in_has_byte    (in_has_byte),
    .in_path_end    (in_path_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_is_status  (out_is_status),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.apply_request(in_path_byte, in_has_byte, in_path_end);
      if (out_valid && out_ready) begin
        board.check_result('{out_char, out_is_status, out_status, out_last_of_run});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_request(input logic [7:0] b, input logic has, input logic fin);
    in_valid = 1'b1;
    in_path_byte = b;
    in_has_byte = has;
    in_path_end = fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic send_path(input byte_q_t p, input bit marker, input bit noisy);
    for (int i = 0; i < p.size(); i++) begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_request(p[i], 1'b1, !marker && i == p.size() - 1);
    end
    if (marker || p.size() == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic byte_q_t str_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q = {q, 8'(s[i])};
    return q;
  endfunction

  function automatic logic [7:0] sep_char();
    return $urandom_range(0, 1) ? CH_SLASH : CH_BSLASH;
  endfunction

  function automatic logic [7:0] seg_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = 8'h61 + 8'($urandom_range(0, 25));
      4, 5: c = CH_UPPER_A + 8'($urandom_range(0, 25));
      6: c = 8'h30 + 8'($urandom_range(0, 9));
      7: c = CH_DOT;
      default: begin
        c = 8'($urandom_range(32, 255));
        while (c == CH_SLASH || c == CH_BSLASH || c == CH_COLON || c == CH_DEL) begin
          c = 8'($urandom_range(32, 255));
        end
      end
    endcase
    return c;
  endfunction

  function automatic byte_q_t long_path(int len);
    byte_q_t p;
    p = {8'h61};
    while (p.size() < len) begin
      if ($urandom_range(0, 9) == 0 && p.size() < len - 1) p = {p, sep_char()};
      p = {p, 8'h61 + 8'($urandom_range(0, 25))};
    end
    return p;
  endfunction

  function automatic byte_q_t make_path();
    byte_q_t p;
    int      nseg;
    if ($urandom_range(0, 99) < 82) begin
      nseg = $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) p = {CH_DOT, sep_char()};
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) repeat ($urandom_range(1, 3)) p = {p, sep_char()};
        case ($urandom_range(0, 15))
          0: p = {p, CH_DOT};
          1: p = {p, CH_DOT, CH_DOT};
          2: repeat ($urandom_range(3, 5)) p = {p, CH_DOT};
          3: p = {p, CH_DOT, CH_DOT, seg_char()};
          default: repeat ($urandom_range(1, 6)) p = {p, seg_char()};
        endcase
      end
      if ($urandom_range(0, 4) == 0) p = {p, sep_char()};
    end else begin
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 3))
          0, 1: p = {p, 8'($urandom_range(0, 255))};
          2: p = {p, seg_char()};
          default: p = {p, sep_char()};
        endcase
      end
    end
    return p;
  endfunction

  initial begin
    byte_q_t p;
    bit      marker;
    int      normal_items;
    int      path_idx;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    p = {};
    send_path(p, 1'b1, 1'b0);
    send_path(str_bytes("a/./B"), 1'b0, 1'b0);
    send_path(str_bytes("q\\..Z"), 1'b0, 1'b0);
    send_path(str_bytes("/x"), 1'b1, 1'b0);
    send_request(8'hA5, 1'b0, 1'b0);
    send_path(str_bytes(".."), 1'b0, 1'b0);
    send_path(str_bytes("..."), 1'b0, 1'b0);
    p = {8'hFF, 8'h1F};
    send_path(p, 1'b0, 1'b0);
    p = {CH_DEL};
    send_path(p, 1'b0, 1'b0);
    p = {CH_COLON};
    send_path(p, 1'b0, 1'b0);
    send_path(str_bytes("./"), 1'b0, 1'b0);

    normal_items = 0;
    path_idx = 0;
    while (normal_items < RANDOM_ITEMS) begin
      if (path_idx == 6) begin
        p = long_path(MAX_LENGTH_DEF + 1);
        send_path(p, 1'b1, 1'b0);
        normal_items += p.size() + 1;
      end else begin
        p = make_path();
        marker = ($urandom_range(0, 2) == 0) || (p.size() == 0);
        send_path(p, marker, 1'b1);
        normal_items += p.size() + int'(marker);
      end
      if (path_idx == 3) hold_req = 1'b1;
      if (normal_items >= QUIET_FROM) quiet = 1'b1;
      path_idx++;
    end
    in_valid = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
